// File: hdl/chsq_pkg.sv
// chsq_pkg: shared types and constants of the chi-square histogram distance block
// used by every module under hdl except chsq_ram; depends on nothing

package chsq_pkg;

   // default sizes, handed to the top-level parameters
   localparam int MAX_QUBITS_DEF = 10;
   localparam int COUNT_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;

   // fixed field widths
   localparam int OP_BITS      = 2;
   localparam int OUTCOME_BITS = 10;
   localparam int LOSS_BITS    = 43;
   localparam int AQ_BITS      = 4;

   localparam logic [LOSS_BITS-1:0] LOSS_MAX = '1;
   localparam logic [AQ_BITS-1:0]   AQ_RESET = 4'd10;

   // register port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [CSR_ADDR_BITS-3:0] {
      REG_ACTIVE_QUBITS = 1'b0
   } reg_type;

   typedef enum logic [OP_BITS-1:0] {
      OP_FIRST   = 2'd0,
      OP_SECOND  = 2'd1,
      OP_COMPUTE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BUMP,
      ST_READ,
      ST_LOAD,
      ST_SQUARE,
      ST_DIV_START,
      ST_DIVIDE,
      ST_ACCUM,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load_item;
      logic pick_second;
      logic bump;
      logic start_walk;
      logic cnt_inc;
      logic cnt_zero;
      logic rd_walk;
      logic sweep;
      logic load_diff;
      logic load_square;
      logic div_start;
      logic div_step;
      logic accumulate;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic bin_nonzero;
      logic walk_last;
      logic sweep_last;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

// File: hdl/chsq_ram.sv
// chsq_ram: generic single-write, single-read ram with registered read data
// no package dependencies

module chsq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old word when both ports hit the same address
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/chsq_ctrl.sv
// chsq_ctrl: sequencer for sample, compute and clearing sweep
// depends on chsq_pkg for state, opcode, command and status types

module chsq_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [chsq_pkg::OP_BITS-1:0] req_operation,
   output logic                         req_ready,
   input  chsq_pkg::status_type         status,
   output chsq_pkg::cmd_type            cmd
);

   chsq_pkg::state_type state_ff, state_in;
   chsq_pkg::op_type    op;

   assign op = chsq_pkg::op_type'(req_operation);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= chsq_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         chsq_pkg::ST_CLEAR: begin
            cmd.sweep   = 1'b1;
            cmd.cnt_inc = 1'b1;
            cmd.rd_walk = 1'b1;
            if (status.sweep_last) begin
               state_in = chsq_pkg::ST_IDLE;
            end
         end
         chsq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item   = 1'b1;
               cmd.pick_second = (op == chsq_pkg::OP_SECOND);
               unique case (op) inside
                  chsq_pkg::OP_FIRST, chsq_pkg::OP_SECOND: begin
                     state_in = chsq_pkg::ST_BUMP;
                  end
                  chsq_pkg::OP_COMPUTE: begin
                     cmd.start_walk = 1'b1;
                     state_in       = chsq_pkg::ST_READ;
                  end
                  default: begin
                     state_in = chsq_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         chsq_pkg::ST_BUMP: begin
            cmd.bump = 1'b1;
            state_in = chsq_pkg::ST_IDLE;
         end
         chsq_pkg::ST_READ: begin
            cmd.rd_walk = 1'b1;
            state_in    = chsq_pkg::ST_LOAD;
         end
         chsq_pkg::ST_LOAD: begin
            cmd.rd_walk = 1'b1;
            if (status.bin_nonzero) begin
               cmd.load_diff = 1'b1;
               state_in      = chsq_pkg::ST_SQUARE;
            end else begin
               cmd.cnt_inc = 1'b1;
               state_in    = status.walk_last ? chsq_pkg::ST_FINISH : chsq_pkg::ST_READ;
            end
         end
         chsq_pkg::ST_SQUARE: begin
            cmd.load_square = 1'b1;
            state_in        = chsq_pkg::ST_DIV_START;
         end
         chsq_pkg::ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = chsq_pkg::ST_DIVIDE;
         end
         chsq_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = chsq_pkg::ST_ACCUM;
            end
         end
         chsq_pkg::ST_ACCUM: begin
            cmd.accumulate = 1'b1;
            cmd.cnt_inc    = 1'b1;
            state_in       = status.walk_last ? chsq_pkg::ST_FINISH : chsq_pkg::ST_READ;
         end
         chsq_pkg::ST_FINISH: begin
            // hold the sum until the result register is free
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.cnt_zero = 1'b1;
               state_in     = chsq_pkg::ST_CLEAR;
            end
         end
         default: begin
            state_in = chsq_pkg::ST_CLEAR;
         end
      endcase
   end

endmodule

// File: hdl/chsq_dp.sv
// chsq_dp: histogram rams, bin walker, squarer, radix-2 divider, accumulator, result word
// depends on chsq_pkg and chsq_ram

module chsq_dp #(
   parameter int MAX_QUBITS = chsq_pkg::MAX_QUBITS_DEF,
   parameter int COUNT_BITS = chsq_pkg::COUNT_BITS_DEF,
   parameter int FRAC_BITS  = chsq_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  chsq_pkg::cmd_type                 cmd,
   output chsq_pkg::status_type              status,
   input  logic [chsq_pkg::OUTCOME_BITS-1:0] req_outcome,
   input  logic [chsq_pkg::AQ_BITS-1:0]      active_qubits,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [chsq_pkg::LOSS_BITS-1:0]    rsp_loss,
   output logic                              rsp_overflow
);

   localparam int DEPTH     = 2 ** MAX_QUBITS;
   localparam int QW        = COUNT_BITS + FRAC_BITS;
   localparam int DIV_CNT_W = $clog2(QW);
   localparam int QSEL_W    = $clog2(MAX_QUBITS + 1);
   localparam int LB        = chsq_pkg::LOSS_BITS;
   localparam int WS        = ((QW > LB) ? QW : LB) + 1;

   // bin walker and item registers
   logic [MAX_QUBITS-1:0] cnt_ff, cnt_in;
   logic [MAX_QUBITS-1:0] idx_ff;
   logic                  sel_ff;
   logic [MAX_QUBITS-1:0] outcome_idx;
   logic [MAX_QUBITS-1:0] last_bin;
   logic [QSEL_W-1:0]     q_eff;

   // ram ports
   logic [MAX_QUBITS-1:0] rd_addr, wr_addr;
   logic [COUNT_BITS-1:0] wr_data, rd_a, rd_b, cur;
   logic                  first_we, second_we, cur_full;

   // arithmetic
   logic [COUNT_BITS-1:0]   diff_ff;
   logic [COUNT_BITS:0]     total_ff;
   logic [2*COUNT_BITS-1:0] sq_ff;
   logic [COUNT_BITS:0]     rem_ff, rem_in;
   logic [QW-1:0]           num_ff, num_in;
   logic [DIV_CNT_W-1:0]    div_cnt_ff;
   logic [COUNT_BITS+1:0]   trial, trial_sub;
   logic                    qbit;
   logic [WS-1:0]           wide_sum;
   logic [LB-1:0]           sum_ff, sum_in;

   // flag and result
   logic          flag_ff;
   logic          rsp_valid_ff;
   logic [LB-1:0] loss_ff;
   logic          ovf_ff;

   assign outcome_idx = MAX_QUBITS'(req_outcome);

   assign q_eff    = (32'(active_qubits) > MAX_QUBITS) ? QSEL_W'(MAX_QUBITS)
                                                       : QSEL_W'(active_qubits);
   assign last_bin = ~({MAX_QUBITS{1'b1}} << q_eff);

   assign rd_addr  = cmd.rd_walk ? cnt_ff : outcome_idx;
   assign cur      = sel_ff ? rd_b : rd_a;
   assign cur_full = &cur;
   assign wr_addr  = cmd.sweep ? cnt_ff : idx_ff;
   assign wr_data  = cmd.sweep ? '0 : cur + COUNT_BITS'(1);
   assign first_we  = cmd.sweep | (cmd.bump & ~sel_ff & ~cur_full);
   assign second_we = cmd.sweep | (cmd.bump & sel_ff & ~cur_full);

   chsq_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_first_ram (
      .clock   (clock),
      .wr_en   (first_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_a)
   );

   chsq_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_second_ram (
      .clock   (clock),
      .wr_en   (second_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_b)
   );

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.start_walk || cmd.cnt_zero) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + MAX_QUBITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         idx_ff <= outcome_idx;
         sel_ff <= cmd.pick_second;
      end
   end

   // restoring divide of (sq << FRAC_BITS) by the bin total, one quotient bit a cycle;
   // the quotient fits QW bits, so the top COUNT_BITS bits seed the remainder
   assign trial     = {rem_ff, num_ff[QW-1]};
   assign trial_sub = trial - {1'b0, total_ff};
   assign qbit      = (trial >= {1'b0, total_ff});

   always_comb begin
      rem_in = rem_ff;
      num_in = num_ff;
      if (cmd.div_start) begin
         rem_in = (COUNT_BITS+1)'(sq_ff[2*COUNT_BITS-1:COUNT_BITS]);
         num_in = QW'(sq_ff[COUNT_BITS-1:0]) << FRAC_BITS;
      end else if (cmd.div_step) begin
         rem_in = qbit ? trial_sub[COUNT_BITS:0] : trial[COUNT_BITS:0];
         num_in = {num_ff[QW-2:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_diff) begin
         diff_ff  <= (rd_a > rd_b) ? (rd_a - rd_b) : (rd_b - rd_a);
         total_ff <= (COUNT_BITS+1)'(rd_a) + (COUNT_BITS+1)'(rd_b);
      end
      if (cmd.load_square) begin
         sq_ff <= (2*COUNT_BITS)'(diff_ff) * (2*COUNT_BITS)'(diff_ff);
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_start) begin
         div_cnt_ff <= DIV_CNT_W'(QW - 1);
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
      end
   end

   // saturating sum of the bin terms
   assign wide_sum = WS'(sum_ff) + WS'(num_ff);

   always_comb begin
      sum_in = sum_ff;
      if (cmd.start_walk) begin
         sum_in = '0;
      end else if (cmd.accumulate) begin
         sum_in = (wide_sum > WS'(chsq_pkg::LOSS_MAX)) ? chsq_pkg::LOSS_MAX : wide_sum[LB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit) begin
            flag_ff <= 1'b0;
         end else if (cmd.bump && cur_full) begin
            flag_ff <= 1'b1;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         loss_ff <= sum_ff;
         ovf_ff  <= flag_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_loss     = loss_ff;
   assign rsp_overflow = ovf_ff;

   assign status.bin_nonzero = (rd_a != '0) || (rd_b != '0);
   assign status.walk_last   = (cnt_ff == last_bin);
   assign status.sweep_last  = &cnt_ff;
   assign status.div_last    = (div_cnt_ff == '0);
   assign status.out_free    = ~rsp_valid_ff | rsp_ready;

   // a count update writes only the selected histogram
   a_one_store: assert property (@(posedge clock) disable iff (reset)
      cmd.bump |-> !(first_we && second_we))
      else $error("count update wrote both histograms");

   // emitting a result clears the sticky flag and raises the result valid
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (!flag_ff && rsp_valid_ff))
      else $error("emit did not clear flag or set valid");

   // the divider always runs the full quotient width
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> (div_cnt_ff == DIV_CNT_W'(QW - 1)))
      else $error("divider step count not loaded");

   // a result is never overwritten before it is taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.emit)
      else $error("result overwritten while stalled");

endmodule

// File: hdl/chi_square_histogram_distance.sv
// chi_square_histogram_distance: top level, register port and controller/datapath hookup
// depends on chsq_pkg, chsq_ctrl, chsq_dp (which holds two chsq_ram)
//
//  port group   direction  handshake                 carries
//  req_*        in         req_valid / req_ready     operation, outcome
//  rsp_*        out        rsp_valid / rsp_ready     loss, overflow
//  p* (apb)     in/out     psel, penable, pready     active_qubits at byte address 0
//
// a sample word is read from ram, then incremented and written back.
// compute reads each bin through the single ram read port and skips an empty one;
// an occupied bin is squared, divided by the one-bit-per-cycle divider and summed;
// the result is then posted and a sweep over all 2^MAX_QUBITS bins zeroes both rams.
// after reset the same sweep runs before req_ready rises.
// a stalled result holds the finished sum; register writes are taken at any time.

module chi_square_histogram_distance #(
   parameter int MAX_QUBITS = chsq_pkg::MAX_QUBITS_DEF,
   parameter int COUNT_BITS = chsq_pkg::COUNT_BITS_DEF,
   parameter int FRAC_BITS  = chsq_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [chsq_pkg::OP_BITS-1:0]       req_operation,
   input  logic [chsq_pkg::OUTCOME_BITS-1:0]  req_outcome,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [chsq_pkg::LOSS_BITS-1:0]     rsp_loss,
   output logic                               rsp_overflow,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [chsq_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [chsq_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [chsq_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                               pready
);

   chsq_pkg::cmd_type    cmd;
   chsq_pkg::status_type status;
   chsq_pkg::reg_type    reg_sel;
   logic [chsq_pkg::AQ_BITS-1:0] aq_ff;
   logic                         wr_strobe;

   assign pready    = 1'b1;
   assign reg_sel   = chsq_pkg::reg_type'(paddr[chsq_pkg::CSR_ADDR_BITS-1:2]);
   assign wr_strobe = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         aq_ff <= chsq_pkg::AQ_RESET;
      end else if (wr_strobe) begin
         unique case (reg_sel)
            chsq_pkg::REG_ACTIVE_QUBITS: begin
               aq_ff <= pwdata[chsq_pkg::AQ_BITS-1:0];
            end
            default: begin
               aq_ff <= aq_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         chsq_pkg::REG_ACTIVE_QUBITS: begin
            prdata = chsq_pkg::CSR_DATA_BITS'(aq_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   chsq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   chsq_dp #(
      .MAX_QUBITS (MAX_QUBITS),
      .COUNT_BITS (COUNT_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_outcome   (req_outcome),
      .active_qubits (aq_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_loss      (rsp_loss),
      .rsp_overflow  (rsp_overflow)
   );

endmodule

// File: test/chi_square_histogram_distance_check.sv
// chi_square_histogram_distance_check: watches the sample, result and register ports,
// keeps its own pair of histograms and predicts each chi-square result; depends on chsq_pkg

module chi_square_histogram_distance_check
   import chsq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [OP_BITS-1:0]       req_operation,
   input  logic [OUTCOME_BITS-1:0]  req_outcome,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [LOSS_BITS-1:0]     rsp_loss,
   input  logic                     rsp_overflow,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   input  logic [CSR_DATA_BITS-1:0] prdata,
   input  logic                     pready,
   output int                       errors,
   output int                       outstanding
);

   localparam int BINS = 1 << MAX_QUBITS_DEF;

   typedef struct packed {
      logic [LOSS_BITS-1:0] loss;
      logic                 overflow;
   } distance_type;

   logic [COUNT_BITS_DEF-1:0] first_hist [BINS];
   logic [COUNT_BITS_DEF-1:0] second_hist [BINS];
   logic                      saturated;
   logic [AQ_BITS-1:0]        qubits;
   distance_type              distance_queue [$];
   int                        fail_count = 0;

   // floor((d*d << frac) / s), split so the shift cannot overflow
   function automatic logic [63:0] chi_term(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] d, s, sq;
      d = (a > b) ? a - b : b - a;
      s = a + b;
      sq = d * d;
      return ((sq / s) << FRAC_BITS_DEF) + (((sq % s) << FRAC_BITS_DEF) / s);
   endfunction

   function automatic distance_type chi_square_sum();
      int           walked;
      logic [63:0]  total, t;
      distance_type res;
      walked = 1 << ((int'(qubits) > MAX_QUBITS_DEF) ? MAX_QUBITS_DEF : int'(qubits));
      total = '0;
      for (int i = 0; i < walked; i++) begin
         if (first_hist[i] != '0 || second_hist[i] != '0) begin
            t = chi_term(64'(first_hist[i]), 64'(second_hist[i]));
            if (t > 64'(LOSS_MAX) - total) total = 64'(LOSS_MAX);
            else total = total + t;
         end
      end
      res.loss = total[LOSS_BITS-1:0];
      res.overflow = saturated;
      return res;
   endfunction

   task automatic clear_hists();
      for (int i = 0; i < BINS; i++) begin
         first_hist[i] = '0;
         second_hist[i] = '0;
      end
      saturated = 1'b0;
   endtask

   task automatic bump_bin(input logic to_second, input logic [OUTCOME_BITS-1:0] outcome);
      int idx;
      idx = int'(outcome) & (BINS - 1);
      if (!to_second) begin
         if (&first_hist[idx]) saturated = 1'b1;
         else first_hist[idx]++;
      end else begin
         if (&second_hist[idx]) saturated = 1'b1;
         else second_hist[idx]++;
      end
   endtask

   always @(posedge clock) begin
      distance_type want;
      if (reset) begin
         clear_hists();
         qubits = AQ_RESET;
         distance_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (distance_queue.size() == 0) begin
               fail_count++;
               $display("%0t: result word with none expected: loss %h overflow %b",
                        $time, rsp_loss, rsp_overflow);
            end else begin
               want = distance_queue.pop_front();
               if (rsp_loss !== want.loss) begin
                  fail_count++;
                  $display("%0t: loss expected %h actual %h", $time, want.loss, rsp_loss);
               end
               if (rsp_overflow !== want.overflow) begin
                  fail_count++;
                  $display("%0t: overflow expected %b actual %b",
                           $time, want.overflow, rsp_overflow);
               end
            end
         end
         if (req_valid && req_ready) begin
            case (op_type'(req_operation))
               OP_FIRST: bump_bin(1'b0, req_outcome);
               OP_SECOND: bump_bin(1'b1, req_outcome);
               OP_COMPUTE: begin
                  distance_queue.insert(distance_queue.size(), chi_square_sum());
                  clear_hists();
               end
               default: ;
            endcase
         end
         if (psel && penable && pready && paddr[CSR_ADDR_BITS-1:2] == REG_ACTIVE_QUBITS) begin
            if (pwrite) begin
               qubits = pwdata[AQ_BITS-1:0];
            end else if (prdata[AQ_BITS-1:0] !== qubits) begin
               fail_count++;
               $display("%0t: active_qubits read expected %h actual %h",
                        $time, qubits, prdata[AQ_BITS-1:0]);
            end
         end
      end
      errors <= fail_count;
      outstanding <= distance_queue.size();
   end

endmodule

// File: test/chi_square_histogram_distance_test.sv
// chi_square_histogram_distance_test: clock, reset, sample/compute words and register
// writes for the chi-square block; depends on chsq_pkg and chi_square_histogram_distance_check

module chi_square_histogram_distance_test;
   import chsq_pkg::*;

   localparam int SETTLE_CYCLES = (1 << MAX_QUBITS_DEF) + 64;
   localparam int PHASE_ITEMS   = 92;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic [OP_BITS-1:0]       req_operation = '0;
   logic [OUTCOME_BITS-1:0]  req_outcome = '0;
   logic                     rsp_ready = 1'b0;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic                     req_ready;
   logic                     rsp_valid;
   logic [LOSS_BITS-1:0]     rsp_loss;
   logic                     rsp_overflow;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;
   int                       errors;
   int                       outstanding;
   bit                       steady = 1'b0;

   chi_square_histogram_distance dut (.*);

   chi_square_histogram_distance_check distance_check (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_word(input op_type op, input logic [OUTCOME_BITS-1:0] outc);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_outcome <= outc;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid, wait for every result, then let the clearing sweep finish
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [CSR_DATA_BITS-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write;
      paddr <= {REG_ACTIVE_QUBITS, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_qubits(input logic [AQ_BITS-1:0] aq);
      logic [CSR_DATA_BITS-1:0] data;
      wait_idle();
      data = ($urandom() & ~32'hF) | 32'(aq);
      csr_access(1'b1, data);
      @(posedge clock);
      csr_access(1'b0, '0);
   endtask

   task automatic random_phase(input logic [AQ_BITS-1:0] aq, input int items);
      int                      span;
      int                      r;
      op_type                  op;
      logic [OUTCOME_BITS-1:0] outc;
      set_qubits(aq);
      span = 1 << ((int'(aq) > MAX_QUBITS_DEF) ? MAX_QUBITS_DEF : int'(aq));
      for (int i = 0; i < items; i++) begin
         if (i % 23 == 0) steady = ($urandom_range(0, 4) == 0);
         r = $urandom_range(0, 99);
         outc = OUTCOME_BITS'($urandom_range(0, 1023));
         if (r < 3) begin
            op = OP_NONE;
         end else if (r < 8) begin
            op = OP_COMPUTE;
         end else begin
            op = ($urandom_range(0, 1) == 0) ? OP_FIRST : OP_SECOND;
            // mostly walked bins, some piled on a few hot bins, the rest anywhere
            if (r < 78) outc = OUTCOME_BITS'($urandom_range(0, span - 1));
            else if (r < 92) outc = OUTCOME_BITS'($urandom_range(0, (span < 4) ? span - 1 : 3));
         end
         send_word(op, outc);
      end
      steady = 1'b0;
      send_word(OP_COMPUTE, OUTCOME_BITS'($urandom_range(0, 1023)));
   endtask

   initial begin
      int r;
      int n;
      @(posedge clock);
      forever begin
         r = $urandom_range(0, 99);
         if (r < 55) n = 0;
         else if (r < 85) n = $urandom_range(1, 3);
         else if (r < 95) n = $urandom_range(4, 12);
         else n = $urandom_range(30, 90);
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   initial begin
      logic [AQ_BITS-1:0] plan [12] = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd10, 4'd5,
                                        4'd2, 4'd12, 4'd0, 4'd3, 4'd1, 4'd6};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset setting: empty compute, edge outcomes, ignored code, equal counts
      send_word(OP_COMPUTE, 10'd0);
      send_word(OP_FIRST, 10'd0);
      send_word(OP_SECOND, 10'd1023);
      send_word(OP_FIRST, 10'd1023);
      send_word(OP_FIRST, 10'd1023);
      send_word(OP_NONE, 10'd1023);
      send_word(OP_NONE, 10'd0);
      send_word(OP_SECOND, 10'd5);
      send_word(OP_FIRST, 10'd5);
      send_word(OP_COMPUTE, 10'd1023);
      send_word(OP_COMPUTE, 10'd0);

      // zero qubits walks bin 0 only
      set_qubits(4'd0);
      send_word(OP_FIRST, 10'd0);
      send_word(OP_FIRST, 10'd1);
      send_word(OP_FIRST, 10'd0);
      send_word(OP_COMPUTE, 10'd0);

      // above the maximum behaves as the maximum
      set_qubits(4'd15);
      send_word(OP_FIRST, 10'd1023);
      send_word(OP_SECOND, 10'd512);
      send_word(OP_FIRST, 10'd700);
      send_word(OP_COMPUTE, 10'd0);

      foreach (plan[p]) random_phase(plan[p], PHASE_ITEMS);

      wait_idle();
      if (errors == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
